// File: rtl/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  // Pixels per output word. The word format always carries four pixel fields.
  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned EFF_LANES  = (NUM_LANES > 4) ? 4 : ((NUM_LANES < 1) ? 1 : NUM_LANES);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned OUT_DATA_W  = 200;

  // Record modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_RGB332 = 2'd1;
  localparam logic [1:0] MODE_RGBA   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RECORD_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT = 2'd1;

  // Header byte count once width and height are complete
  localparam logic [2:0] HDR_BYTES      = 3'd4;
  // Record byte position of the count byte in RGBA and in one-byte modes
  localparam logic [2:0] RGBA_COUNT_POS = 3'd4;
  localparam logic [2:0] BYTE_COUNT_POS = 3'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_MARK   = 8'h80;

  typedef struct packed {
    logic accept;  // input transaction this cycle
    logic load;    // load the next pixel word into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_start;  // the byte on the input is a non-zero count
    logic last_word;  // the pending word is the last of the run
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: rtl/rbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire rbd_pkg::ctrl_status_t status,
  output rbd_pkg::ctrl_cmd_t        cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd.accept = (state == ST_IDLE) && s_tvalid;
    cmd.load   = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.accept && status.run_start) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.load && status.last_word) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rbd_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [7:0]                           data_byte,
  input  wire logic                                 end_of_file,
  input  wire logic                                 cfg_valid,
  input  wire logic [rbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [31:0]                          cfg_data,
  input  wire rbd_pkg::ctrl_cmd_t                   cmd,
  output rbd_pkg::ctrl_status_t                     status,
  output logic [rbd_pkg::OUT_DATA_W-1:0]            word_data,
  output logic                                      word_last,
  output logic                                      word_past
);

  localparam logic [7:0] LANES8 = 8'(rbd_pkg::EFF_LANES);

  // Configuration
  logic [1:0]  record_mode;
  logic [31:0] transparent_colour;

  // Parser state
  logic [2:0]  header_bytes_seen;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [31:0] pixel_limit;
  logic [2:0]  record_byte_pos;
  logic [31:0] held_colour_bytes;
  logic [31:0] pixel_counter;

  // Run in progress
  logic [31:0] run_colour;
  logic [7:0]  run_left;
  logic [31:0] run_index;

  // Output word fields
  logic [31:0] pix_a, pix_b, pix_c, pix_d;
  logic [2:0]  lanes_valid;
  logic [31:0] start_index;
  logic [15:0] image_width, image_height;

  logic        in_header;
  logic        is_count;
  logic [31:0] colour;
  logic [7:0]  b0;
  logic [2:0]  word_lanes;
  logic [32:0] last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_mode        <= rbd_pkg::MODE_PLAIN;
      transparent_colour <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == rbd_pkg::REG_RECORD_MODE) begin
        record_mode <= cfg_data[1:0];
      end else if (cfg_index == rbd_pkg::REG_TRANSPARENT) begin
        transparent_colour <= cfg_data;
      end
    end
  end

  always_comb begin
    in_header = (header_bytes_seen != rbd_pkg::HDR_BYTES);
    if (record_mode == rbd_pkg::MODE_RGBA) begin
      is_count = (record_byte_pos >= rbd_pkg::RGBA_COUNT_POS);
    end else begin
      is_count = (record_byte_pos >= rbd_pkg::BYTE_COUNT_POS);
    end

    b0 = held_colour_bytes[7:0];
    if (record_mode == rbd_pkg::MODE_RGBA) begin
      if (held_colour_bytes[31:24] != rbd_pkg::ALPHA_OPAQUE) begin
        colour = transparent_colour;
      end else begin
        colour = {rbd_pkg::ALPHA_MARK, b0, held_colour_bytes[15:8], held_colour_bytes[23:16]};
      end
    end else if (record_mode == rbd_pkg::MODE_RGB332) begin
      if ({24'd0, b0} == transparent_colour) begin
        colour = transparent_colour;
      end else begin
        colour = {27'd0, b0[7], b0[5:4], b0[2:1]};
      end
    end else begin
      colour = {24'd0, b0};
    end

    status.run_start = !in_header && is_count && (data_byte != 8'd0);
    status.last_word = (run_left <= LANES8);

    word_lanes = status.last_word ? run_left[2:0] : 3'(rbd_pkg::EFF_LANES);
    // Indices of the word run from run_index to run_index + lanes - 1; if that
    // range wraps it contains the all-ones index, which is always past the end.
    last_pos   = {1'b0, run_index} + {30'd0, word_lanes} - 33'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes_seen <= '0;
      width_reg         <= '0;
      height_reg        <= '0;
      pixel_limit       <= '0;
      record_byte_pos   <= '0;
      held_colour_bytes <= '0;
      pixel_counter     <= '0;
    end else if (cmd.accept) begin
      if (in_header) begin
        unique case (header_bytes_seen[1:0])
          2'd0: width_reg  <= {data_byte, 8'd0};
          2'd1: width_reg[7:0] <= data_byte;
          2'd2: height_reg <= {data_byte, 8'd0};
          default: begin
            height_reg[7:0] <= data_byte;
            pixel_limit     <= width_reg * {height_reg[15:8], data_byte};
          end
        endcase
        header_bytes_seen <= header_bytes_seen + 3'd1;
      end else if (is_count) begin
        record_byte_pos   <= '0;
        held_colour_bytes <= '0;
        pixel_counter     <= pixel_counter + {24'd0, data_byte};
      end else begin
        held_colour_bytes[{record_byte_pos[1:0], 3'b000} +: 8] <= data_byte;
        record_byte_pos <= record_byte_pos + 3'd1;
      end
      if (end_of_file) begin
        header_bytes_seen <= '0;
        record_byte_pos   <= '0;
        held_colour_bytes <= '0;
        pixel_counter     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_header && is_count) begin
      run_colour <= colour;
      run_left   <= data_byte;
      run_index  <= pixel_counter;
    end else if (cmd.load) begin
      run_left  <= run_left - {5'd0, word_lanes};
      run_index <= run_index + {29'd0, word_lanes};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_a        <= run_colour;
      pix_b        <= (word_lanes > 3'd1) ? run_colour : 32'd0;
      pix_c        <= (word_lanes > 3'd2) ? run_colour : 32'd0;
      pix_d        <= (word_lanes > 3'd3) ? run_colour : 32'd0;
      lanes_valid  <= word_lanes;
      start_index  <= run_index;
      image_width  <= width_reg;
      image_height <= height_reg;
      word_last    <= status.last_word;
      word_past    <= last_pos[32] || (last_pos[31:0] >= pixel_limit);
    end
  end

  assign word_data = {5'd0, image_height, image_width, start_index, lanes_valid,
                      pix_d, pix_c, pix_b, pix_a};

endmodule

`default_nettype wire

// File: rtl/rle_bitmap_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  file byte, end-of-file marker
// m_*       out        m_tvalid / m_tready  pixel word of up to four pixels
// cfg_*     in         cfg_valid / cfg_ready register index and write data
//
// A header or colour byte leaves the input open. A non-zero count byte is taken
// and then holds off the input while the run engine loads one pixel word per
// cycle into the output register; the input opens again in the cycle after the
// last word is loaded. A stalled output holds the engine. Reset is synchronous
// and clears all parser state and the configuration registers.

module rle_bitmap_decoder_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Input stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,   // [7:0] data_byte
  input  wire logic                                 s_tlast,   // end_of_file
  // Output stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [31:0] pixel_a, [63:32] pixel_b, [95:64] pixel_c, [127:96] pixel_d,
  // [130:128] lanes_valid, [162:131] start_index, [178:163] image_width,
  // [194:179] image_height, [199:195] zero
  output logic [rbd_pkg::OUT_DATA_W-1:0]            m_tdata,
  output logic                                      m_tlast,   // run_done
  output logic                                      m_tuser,   // past_end
  // Configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [31:0]                          cfg_data
);

  rbd_pkg::ctrl_cmd_t    cmd;
  rbd_pkg::ctrl_status_t status;

  // Registers are written whenever asked; the block is idle by agreement.
  assign cfg_ready = 1'b1;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rbd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_tdata),
    .end_of_file (s_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .word_data   (m_tdata),
    .word_last   (m_tlast),
    .word_past   (m_tuser)
  );

endmodule

`default_nettype wire

// File: dv/rle_bitmap_decoder_top_tb.sv
`timescale 1ns / 1ps

module rle_bitmap_decoder_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on any channel
  localparam int DRAIN_CYCLES   = 16;    // quiet cycles before a register write or the end
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int ITEM_TARGET    = 200;   // directed part and random files together

  // One expected pixel word.
  typedef struct packed {
    logic [3:0][31:0] pixels;
    logic [2:0]       lanes;
    logic [31:0]      first_index;
    logic [15:0]      width;
    logic [15:0]      height;
    logic             done;
    logic             past;
  } pixel_word_t;

  class rle_pixel_scoreboard;
    // Configuration and parser state, mirroring the block.
    logic [1:0]  mode;
    logic [31:0] transp;
    logic [2:0]  hdr_seen;
    logic [15:0] width_r;
    logic [15:0] height_r;
    logic [31:0] limit;
    logic [2:0]  rec_pos;
    logic [31:0] held;
    logic [31:0] pix_idx;

    pixel_word_t pending_words[$];
    int          errors;
    int          words_seen;

    function new();
      mode     = rbd_pkg::MODE_PLAIN;
      transp   = '0;
      hdr_seen = '0;
      width_r  = '0;
      height_r = '0;
      limit    = '0;
      rec_pos  = '0;
      held     = '0;
      pix_idx  = '0;
      errors   = 0;
      words_seen = 0;
    endfunction

    function void note_config(logic [rbd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      if (idx == rbd_pkg::REG_RECORD_MODE) mode = data[1:0];
      else if (idx == rbd_pkg::REG_TRANSPARENT) transp = data;
    endfunction

    function logic [31:0] decode_colour();
      logic [7:0] c0;
      logic [1:0] r;
      logic [2:0] g;
      logic [2:0] bl;
      c0 = held[7:0];
      if (mode == rbd_pkg::MODE_RGBA) begin
        // Anything short of fully opaque alpha counts as transparent.
        if (held[31:24] != 8'hFF) return transp;
        return {8'h80, held[7:0], held[15:8], held[23:16]};
      end
      if (mode == rbd_pkg::MODE_RGB332) begin
        if ({24'd0, c0} == transp) return transp;
        r  = c0[7:6];
        g  = c0[5:3];
        bl = c0[2:0];
        return (32'(r >> 1) << 4) + (32'(g >> 1) << 2) + 32'(bl >> 1);
      end
      // Plain mode, and the unused mode three, pass the first byte through.
      return {24'd0, c0};
    endfunction

    function void expand_run(logic [31:0] colour, logic [7:0] count);
      pixel_word_t w;
      int left;
      int k;
      int i;
      left = count;
      while (left != 0) begin
        k = (left < 4) ? left : 4;
        w = '0;
        for (i = 0; i < k; i++) begin
          w.pixels[i] = colour;
          if (pix_idx + 32'(i) >= limit) w.past = 1'b1;
        end
        left -= k;
        w.lanes       = 3'(k);
        w.first_index = pix_idx;
        w.done        = (left == 0);
        w.width       = width_r;
        w.height      = height_r;
        pending_words.push_back(w);
        pix_idx += 32'(k);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      int rec_len;
      if (hdr_seen < 3'd4) begin
        case (hdr_seen)
          3'd0: width_r = {b, 8'h00};
          3'd1: width_r[7:0] = b;
          3'd2: height_r = {b, 8'h00};
          default: begin
            height_r[7:0] = b;
            limit = 32'(width_r) * 32'(height_r);
          end
        endcase
        hdr_seen++;
      end else begin
        rec_len = (mode == rbd_pkg::MODE_RGBA) ? 5 : 2;
        if (int'(rec_pos) + 1 >= rec_len) begin
          expand_run(decode_colour(), b);
          rec_pos = '0;
          held    = '0;
        end else begin
          held |= 32'(b) << {rec_pos[1:0], 3'b000};
          rec_pos++;
        end
      end
      if (eof) begin
        hdr_seen = '0;
        rec_pos  = '0;
        held     = '0;
        pix_idx  = '0;
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR word %0d %s: got 0x%0h, want 0x%0h", words_seen, what, got, want);
    endtask

    task check_word(logic [rbd_pkg::OUT_DATA_W-1:0] td, logic last, logic user);
      pixel_word_t want;
      int i;
      if (pending_words.size() == 0) begin
        report("arrived with nothing pending", td[31:0], 32'd0);
        return;
      end
      want = pending_words.pop_front();
      for (i = 0; i < 4; i++)
        if (td[32*i +: 32] !== want.pixels[i])
          report($sformatf("pixel lane %0d", i), td[32*i +: 32], want.pixels[i]);
      if (td[130:128] !== want.lanes) report("lanes_valid", 32'(td[130:128]), 32'(want.lanes));
      if (td[162:131] !== want.first_index)
        report("start_index", td[162:131], want.first_index);
      if (td[178:163] !== want.width) report("image_width", 32'(td[178:163]), 32'(want.width));
      if (td[194:179] !== want.height)
        report("image_height", 32'(td[194:179]), 32'(want.height));
      if (td[199:195] !== 5'd0) report("padding", 32'(td[199:195]), 32'd0);
      if (last !== want.done) report("run_done", 32'(last), 32'(want.done));
      if (user !== want.past) report("past_end", 32'(user), 32'(want.past));
      words_seen++;
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [rbd_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                            m_tlast;
  logic                            m_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]                     cfg_data;

  rle_pixel_scoreboard sb;
  logic [1:0] cur_mode;
  int         items_sent  = 0;
  int         burst_left  = 0;
  int         idle_cycles = 0;
  logic       hold_off    = 1'b0;

  rle_bitmap_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every accepted pixel word is checked against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1)
      sb.check_word(m_tdata, m_tlast, m_tuser);
  end

  // The run is declared hung when no channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((s_tvalid & s_tready) === 1'b1 || (m_tvalid & m_tready) === 1'b1 ||
        (cfg_valid & cfg_ready) === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rle_bitmap_decoder_top");
      $finish;
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed
  // pattern, and goes quiet altogether during the hold-off.
  initial begin
    int   phase;
    int   cyc;
    logic rdy;
    m_tready = 1'b0;
    phase = 0;
    cyc   = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 48 == 0) phase = $urandom_range(0, 3);
      case (phase)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 4) != 0);
        default: rdy = ((cyc % 4) < 2);
      endcase
      if (hold_off) rdy = 1'b0;
      m_tready <= rdy;
    end
  end

  // Once the random part is under way, the receiver holds off for a long
  // stretch while the sender keeps offering bytes, so the block backs up.
  initial begin
    wait (items_sent >= 100);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eof;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_byte(b, eof);
    items_sent++;
  endtask

  // Waits until every expected word has come out and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, data);
    if (idx == rbd_pkg::REG_RECORD_MODE) cur_mode = data[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends the header; eof_at names the header byte (1 to 4) that ends the file.
  task automatic send_header(input logic [15:0] w, input logic [15:0] h, input int eof_at);
    logic [7:0] hb[4];
    hb = '{w[15:8], w[7:0], h[15:8], h[7:0]};
    for (int i = 0; i < 4; i++) begin
      send_byte(hb[i], eof_at == i + 1);
      if (eof_at == i + 1) return;
    end
  endtask

  // Colour bytes for the current mode, then the count. Now and then the mode
  // is changed between the first colour byte and the rest of the record.
  task automatic send_record(input logic [31:0] colour, input logic [7:0] count,
                             input logic eof, input logic may_change);
    int n;
    n = (cur_mode == rbd_pkg::MODE_RGBA) ? 4 : 1;
    for (int i = 0; i < n; i++) begin
      send_byte(colour[8*i +: 8], 1'b0);
      if (i == 0 && may_change && !hold_off && $urandom_range(0, 24) == 0) begin
        settle();
        write_reg(rbd_pkg::REG_RECORD_MODE, 32'($urandom_range(0, 3)));
      end
    end
    send_byte(count, eof);
  endtask

  task automatic send_random_record(input logic eof);
    logic [31:0] colour;
    logic [7:0]  count;
    int          pick;
    colour = $urandom;
    if (cur_mode == rbd_pkg::MODE_RGBA && $urandom_range(0, 1) == 1) colour[31:24] = 8'hFF;
    if (cur_mode == rbd_pkg::MODE_RGB332 && $urandom_range(0, 3) == 0)
      colour[7:0] = sb.transp[7:0];
    pick = $urandom_range(0, 19);
    case (pick)
      0:       count = 8'd0;
      1:       count = 8'd255;
      2:       count = 8'($urandom_range(13, 254));
      default: count = 8'($urandom_range(1, 12));
    endcase
    send_record(colour, count, eof, 1'b1);
  endtask

  task automatic send_random_file();
    int          kind;
    int          n;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] colour;
    case ($urandom_range(0, 5))
      0:       begin w = 16'($urandom_range(0, 3)); h = 16'd0; end
      1:       begin w = 16'hFFFF; h = 16'hFFFF; end
      2:       begin w = 16'($urandom); h = 16'($urandom); end
      default: begin w = 16'($urandom_range(1, 8)); h = 16'($urandom_range(1, 8)); end
    endcase
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // Noise: bytes with no structure at all.
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
    end else if (kind == 1) begin
      send_header(w, h, $urandom_range(1, 4));
    end else begin
      send_header(w, h, 0);
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_random_record(kind >= 4 && i == n - 1);
      if (kind < 4) begin
        // Broken file: it ends inside a record.
        colour = $urandom;
        n = (cur_mode == rbd_pkg::MODE_RGBA) ? $urandom_range(1, 4) : 1;
        for (int i = 0; i < n; i++) send_byte(colour[8*i +: 8], i == n - 1);
      end
    end
  endtask

  task automatic reconfigure();
    logic [31:0] v;
    settle();
    v = $urandom;
    v[1:0] = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) v[31:2] = '0;
    write_reg(rbd_pkg::REG_RECORD_MODE, v);
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0:       v = 32'd0;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'($urandom_range(0, 255));
        default: v = $urandom;
      endcase
      write_reg(rbd_pkg::REG_TRANSPARENT, v);
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_mode  = rbd_pkg::MODE_PLAIN;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plain colours in a 2 by 3 image, with a zero count and extreme bytes.
    write_reg(rbd_pkg::REG_RECORD_MODE, 32'(rbd_pkg::MODE_PLAIN));
    write_reg(rbd_pkg::REG_TRANSPARENT, 32'hFFFF_FFFF);
    send_header(16'd2, 16'd3, 0);
    send_record(32'h0000_00FF, 8'd5, 1'b0, 1'b0);
    send_record(32'h0000_0000, 8'd0, 1'b0, 1'b0);

    // Reduced RGB332 in the same file: a transparent byte, then the longest
    // run, which runs past the end of the image.
    settle();
    write_reg(rbd_pkg::REG_RECORD_MODE, 32'(rbd_pkg::MODE_RGB332));
    write_reg(rbd_pkg::REG_TRANSPARENT, 32'h0000_00B6);
    send_record(32'h0000_00B6, 8'd3, 1'b0, 1'b0);
    send_record(32'h0000_006D, 8'd255, 1'b0, 1'b0);

    // RGBA records, opaque and then translucent.
    settle();
    write_reg(rbd_pkg::REG_RECORD_MODE, 32'(rbd_pkg::MODE_RGBA));
    write_reg(rbd_pkg::REG_TRANSPARENT, 32'h1234_5678);
    send_record(32'hFF80_00FF, 8'd2, 1'b0, 1'b0);
    send_record(32'hFE33_2211, 8'd1, 1'b0, 1'b0);

    // Two colour bytes of an RGBA record, then the mode drops to the unused
    // value three, so the next byte is the count of a one-byte record.
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    settle();
    write_reg(rbd_pkg::REG_RECORD_MODE, 32'hFFFF_FFFF);
    send_byte(8'd3, 1'b1);

    // A file that ends inside its header.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (!hold_off && $urandom_range(0, 2) == 0) reconfigure();
      send_random_file();
    end

    settle();
    if (sb.errors == 0)
      $display("PASS rle_bitmap_decoder_top");
    else
      $display("FAIL rle_bitmap_decoder_top");
    $finish;
  end

endmodule
